// ===== rtl/msss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msss_pkg;

    localparam int SLOT_COUNT  = 10;
    localparam int SLOT_W      = 4;
    localparam int VALUE_W     = 14;
    localparam int CNT_W       = 4;
    localparam int BCD_W       = 16;

    localparam logic [15:0] VALUE_LIMIT   = 16'd9999;
    localparam logic [7:0]  BLANK_PATTERN = 8'hFF;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SHOW  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CONV  = 3'b010,
        ST_STORE = 3'b100
    } state_t;

    function automatic logic [7:0] digit_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0: code = 8'hC0;
            4'd1: code = 8'hF9;
            4'd2: code = 8'hA4;
            4'd3: code = 8'hB0;
            4'd4: code = 8'h99;
            4'd5: code = 8'h92;
            4'd6: code = 8'h82;
            4'd7: code = 8'hF8;
            4'd8: code = 8'h80;
            4'd9: code = 8'h90;
            default: code = BLANK_PATTERN;
        endcase
        return code;
    endfunction

    // scan order: slots 1,2,3,5,6,7,0,4,8,9
    function automatic logic [SLOT_W-1:0] step_slot(input logic [SLOT_W-1:0] step);
        logic [SLOT_W-1:0] slot;
        case (step)
            4'd0: slot = 4'd1;
            4'd1: slot = 4'd2;
            4'd2: slot = 4'd3;
            4'd3: slot = 4'd5;
            4'd4: slot = 4'd6;
            4'd5: slot = 4'd7;
            4'd6: slot = 4'd0;
            4'd7: slot = 4'd4;
            4'd8: slot = 4'd8;
            4'd9: slot = 4'd9;
            default: slot = 4'd0;
        endcase
        return slot;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/multiplexed_seven_segment_scanner_unit.sv =====
// Scan tick: result valid in the cycle after the item is accepted; write: slot registered on accept.
// Show: accept, then per value 14 shift-add-3 steps and a store; the single
//   binary-to-BCD shift unit converts the two values one after the other.
// Ready is held low during a show; a tick also waits for a pending result.
// Synchronous active-low reset clears all slots, the scan step and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_seven_segment_scanner_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [15:0] s_first_value,
    input  wire logic [15:0] s_second_value,
    input  wire logic [3:0]  s_slot_index,
    input  wire logic [7:0]  s_slot_pattern,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_digit_select,
    output logic [7:0]       m_segment_pattern
);
    import msss_pkg::*;

    state_t                   state_reg, state_next;
    logic [7:0]               slots_reg [SLOT_COUNT];
    logic [SLOT_W-1:0]        scan_step_reg;
    logic                     m_valid_reg;
    logic [15:0]              m_digit_select_reg;
    logic [7:0]               m_segment_pattern_reg;

    logic [VALUE_W-1:0]       second_val_reg;
    logic                     first_ok_reg, second_ok_reg;
    logic                     lane_reg;
    logic [VALUE_W-1:0]       bin_reg, bin_next;
    logic [BCD_W-1:0]         bcd_reg, bcd_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [BCD_W-1:0]         bcd_adj;
    logic [3:0]               nib;
    logic                     accept;
    logic                     tick_fire;
    mode_t                    mode;
    logic                     group_ok;
    logic [3:0]               blank;

    assign mode    = mode_t'(s_mode);
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready || mode != MODE_TICK);
    assign accept  = s_valid && s_ready;
    assign tick_fire = accept && (mode == MODE_TICK)
                       && (scan_step_reg < SLOT_W'(SLOT_COUNT));

    assign m_valid           = m_valid_reg;
    assign m_digit_select    = m_digit_select_reg;
    assign m_segment_pattern = m_segment_pattern_reg;

    // shift-add-3 step
    always_comb begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < 4; i++) begin
            nib = bcd_reg[4*i +: 4];
            if (nib >= 4'd5) begin
                bcd_adj[4*i +: 4] = nib + 4'd3;
            end
        end
        bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
        bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
    end

    assign group_ok = lane_reg ? second_ok_reg : first_ok_reg;

    // leading-zero blanking, most significant digit first
    always_comb begin
        blank[0] = (bcd_reg[15:12] == 4'd0);
        blank[1] = blank[0] && (bcd_reg[11:8] == 4'd0);
        blank[2] = blank[1] && (bcd_reg[7:4] == 4'd0);
        blank[3] = blank[2] && (bcd_reg[3:0] == 4'd0);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && mode == MODE_SHOW) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (cnt_reg == CNT_W'(VALUE_W - 1)) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                state_next = lane_reg ? ST_IDLE : ST_CONV;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_step_reg <= '0;
            m_valid_reg   <= 1'b0;
            lane_reg      <= 1'b0;
            cnt_reg       <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slots_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (tick_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (mode)
                            MODE_TICK: begin
                                if (scan_step_reg >= SLOT_W'(SLOT_COUNT)) begin
                                    scan_step_reg <= '0;
                                end else begin
                                    scan_step_reg <= (scan_step_reg == SLOT_W'(SLOT_COUNT - 1))
                                                   ? '0 : scan_step_reg + 1'b1;
                                end
                            end
                            MODE_SHOW: begin
                                lane_reg <= 1'b0;
                                cnt_reg  <= '0;
                            end
                            MODE_WRITE: begin
                                if (s_slot_index < SLOT_W'(SLOT_COUNT)) begin
                                    slots_reg[s_slot_index] <= s_slot_pattern;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CONV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_STORE: begin
                    if (group_ok) begin
                        for (int i = 0; i < 4; i++) begin
                            slots_reg[SLOT_W'({lane_reg, 2'(i)})] <=
                                blank[i] ? BLANK_PATTERN : digit_code(bcd_reg[4*(3-i) +: 4]);
                        end
                    end
                    lane_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && accept && mode == MODE_TICK) begin
            m_digit_select_reg    <= 16'hFFFF & ~(16'd1 << scan_step_reg);
            m_segment_pattern_reg <= slots_reg[step_slot(scan_step_reg)];
        end
        if (state_reg == ST_IDLE && accept && mode == MODE_SHOW) begin
            first_ok_reg   <= (s_first_value <= VALUE_LIMIT);
            second_ok_reg  <= (s_second_value <= VALUE_LIMIT);
            second_val_reg <= s_second_value[VALUE_W-1:0];
            bin_reg        <= s_first_value[VALUE_W-1:0];
            bcd_reg        <= '0;
        end else if (state_reg == ST_CONV) begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end else if (state_reg == ST_STORE) begin
            bin_reg <= second_val_reg;
            bcd_reg <= '0;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        scan_step_reg < SLOT_W'(SLOT_COUNT))
        else $error("scan step out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(accept && mode == MODE_TICK))
        else $error("result without tick item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready)
        else $error("ready during conversion");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $countones(~m_digit_select_reg) == 1)
        else $error("select word not one-cold");

endmodule

`default_nettype wire
